// File: rtl/sorted_priority_list_macros.svh
// Assertion macros used by the sorted priority list checker.
`ifndef SORTED_PRIORITY_LIST_MACROS_SVH
`define SORTED_PRIORITY_LIST_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define SPL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority list check failed");

// Next-cycle implication, disabled while rst is high.
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority list check failed");

`endif

// File: rtl/spl_pkg.sv
// Types, constants and codes of the sorted priority list.
`default_nettype none
package spl_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RANK_W  = 8;
   localparam int COST_W  = 16;
   localparam int TAG_W   = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int REQ_W   = RANK_W + COST_W + TAG_W;
   localparam int RSP_W   = 16;
   localparam int RSP_PAD = RSP_W - 1 - SLOT_W - COUNT_W;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [COST_W-1:0] cost;
      logic [RANK_W-1:0] rank;
   } entry_type;

   typedef struct packed {
      logic [RSP_PAD-1:0] pad;
      logic [COUNT_W-1:0] count;
      logic [SLOT_W-1:0]  slot;
      logic               hit;
   } rsp_data_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/spl_cell.sv
// One slot of the sorted list: holds an entry and shifts with its neighbors.
`default_nettype none
module spl_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire spl_pkg::cell_ctrl_type ctrl,
   input  wire spl_pkg::entry_type     left_entry,
   input  wire                         left_valid,
   input  wire                         left_place,
   input  wire spl_pkg::entry_type     right_entry,
   input  wire                         right_valid,
   input  wire                         seen_in,
   output spl_pkg::entry_type          entry,
   output logic                        valid,
   output logic                        place,
   output logic                        seen_out
);
   import spl_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      match;

   // New item sorts at or ahead of this slot (an empty slot always qualifies).
   assign place = !valid_ff ||
                  (ctrl.item.rank > entry_ff.rank) ||
                  ((ctrl.item.rank == entry_ff.rank) && (ctrl.item.cost <= entry_ff.cost));

   assign match    = valid_ff && (entry_ff.tag == ctrl.item.tag);
   assign seen_out = seen_in || match;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (left_place) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else if (place) begin
            entry_in = ctrl.item;
            valid_in = 1'b1;
         end
      end else if (ctrl.remove && seen_out) begin
         // close up behind the removed entry
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

// File: rtl/sorted_priority_list.sv
// Sorted priority list top level: a row of list cells and the response register.
// Every cell compares the command against its own entry in parallel and shifts
// from a neighbor at the accepting edge, and the result lands in an output
// register, so a new command is taken every cycle while the response side keeps
// up. Insert, remove and query see the list as left by the previous command.
// Entries are held by rank descending, then cost ascending; a full list drops
// an insert and reports it.
`default_nettype none
module sorted_priority_list (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire [spl_pkg::REQ_W-1:0]    req_tdata,  // rank, cost, tag
   input  wire [spl_pkg::CMD_W-1:0]    req_tuser,  // cmd
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [spl_pkg::RSP_W-1:0]   rsp_tdata,  // hit, slot, count, zero pad
   output logic [spl_pkg::STAT_W-1:0]  rsp_tuser   // status
);
   import spl_pkg::*;

   entry_type            ent   [DEPTH];
   logic [DEPTH-1:0]     vld;
   logic [DEPTH-1:0]     place;
   logic [DEPTH-1:0]     seen;
   cell_ctrl_type        ctrl;
   entry_type            item;
   logic                 accept;
   logic                 full;
   logic                 any_hit;
   logic [CNT_W-1:0]     ins_pos;
   logic [CNT_W-1:0]     rem_pos;

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic                 hit_ff, hit_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;

   assign item       = entry_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign any_hit    = seen[DEPTH-1];

   // place is a thermometer and seen a prefix OR, so zeros count the position
   assign ins_pos = CNT_W'($countones(~place));
   assign rem_pos = CNT_W'($countones(~seen));

   always_comb begin
      ctrl.item   = item;
      ctrl.insert = accept && (req_tuser == CMD_INSERT) && !full;
      ctrl.remove = accept && (req_tuser == CMD_REMOVE) && any_hit;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_v, left_p, right_v, seen_prev;

      if (i == 0) begin : g_first
         assign left_e    = '0;
         assign left_v    = 1'b0;
         assign left_p    = 1'b0;
         assign seen_prev = 1'b0;
      end else begin : g_mid
         assign left_e    = ent[i-1];
         assign left_v    = vld[i-1];
         assign left_p    = place[i-1];
         assign seen_prev = seen[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
         assign right_v = 1'b0;
      end else begin : g_inner
         assign right_e = ent[i+1];
         assign right_v = vld[i+1];
      end

      spl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_valid  (left_v),
         .left_place  (left_p),
         .right_entry (right_e),
         .right_valid (right_v),
         .seen_in     (seen_prev),
         .entry       (ent[i]),
         .valid       (vld[i]),
         .place       (place[i]),
         .seen_out    (seen[i])
      );
   end

   always_comb begin
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         hit_in       = 1'b0;
         slot_in      = '0;
         unique case (req_tuser)
            CMD_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  slot_in = SLOT_W'(ins_pos);
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (any_hit) begin
                  hit_in  = 1'b1;
                  slot_in = SLOT_W'(rem_pos);
                  cnt_in  = cnt_ff - CNT_W'(1);
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            CMD_QUERY: begin
               if (any_hit) begin
                  hit_in = 1'b1;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // count is captured with the rest of the word
   logic [COUNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      hit_ff    <= hit_in;
      slot_ff   <= slot_in;
      count_ff  <= COUNT_W'(cnt_in);
   end

   always_comb begin
      rsp_data_type d;
      d         = '0;
      d.hit     = hit_ff;
      d.slot    = slot_ff;
      d.count   = count_ff;
      rsp_tdata = d;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;

endmodule
`default_nettype wire

// File: rtl/spl_checker.sv
// Port-level checks for the sorted priority list, bound to the top level.
`default_nettype none
`include "sorted_priority_list_macros.svh"
module spl_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_tready,
   input wire                         rsp_tvalid,
   input wire                         rsp_tready,
   input wire [spl_pkg::RSP_W-1:0]    rsp_tdata,
   input wire [spl_pkg::STAT_W-1:0]   rsp_tuser
);
   import spl_pkg::*;

   rsp_data_type d;
   assign d = rsp_data_type'(rsp_tdata);

   `SPL_ASSERT_IMPLY(a_count_bound, clock, reset, rsp_tvalid, d.count <= COUNT_W'(DEPTH))
   `SPL_ASSERT_IMPLY(a_full_report, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_FULL),
                     (d.count == COUNT_W'(DEPTH)) && !d.hit && (d.slot == '0))
   `SPL_ASSERT_IMPLY(a_hit_done, clock, reset, rsp_tvalid && d.hit, rsp_tuser == STATUS_DONE)
   `SPL_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `SPL_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind sorted_priority_list spl_checker u_spl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// File: tb/tb.sv
// Testbench for the sorted priority list: directed and random commands checked against a predictor.
`timescale 1ns / 100ps
module tb;
   import spl_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 1000;
   localparam int REPORT_LIMIT = 50;

   typedef struct {
      logic [STAT_W-1:0]  status;
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;   // rank, cost, tag
   logic [CMD_W-1:0]    req_tuser;   // cmd
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // hit, slot, count, zero pad
   logic [STAT_W-1:0]   rsp_tuser;   // status

   // Predicted list contents.
   logic [RANK_W-1:0]   list_rank [DEPTH];
   logic [COST_W-1:0]   list_cost [DEPTH];
   logic [TAG_W-1:0]    list_tag  [DEPTH];
   int                  list_count;

   list_result_type     expected_q[$];
   int                  error_count;
   int                  idle_cycles;
   int                  hold_len;
   bit                  tx_idle;
   bit                  rx_idle;

   sorted_priority_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [RANK_W-1:0] rank,
                                input logic [COST_W-1:0] cost, input logic [TAG_W-1:0] tag,
                                output list_result_type res);
      int pos;
      bit found;
      res.status = STATUS_DONE;
      res.hit = 1'b0;
      res.slot = '0;
      found = 1'b0;
      pos = 0;
      case (cmd)
         CMD_INSERT: begin
            if (list_count >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               pos = list_count;
               for (int i = 0; i < list_count && !found; i++) begin
                  if (rank > list_rank[i] || (rank == list_rank[i] && cost <= list_cost[i])) begin
                     pos = i;
                     found = 1'b1;
                  end
               end
               for (int i = list_count; i > pos; i--) begin
                  list_rank[i] = list_rank[i-1];
                  list_cost[i] = list_cost[i-1];
                  list_tag[i]  = list_tag[i-1];
               end
               list_rank[pos] = rank;
               list_cost[pos] = cost;
               list_tag[pos]  = tag;
               list_count++;
               res.slot = pos[SLOT_W-1:0];
            end
         end
         CMD_REMOVE, CMD_QUERY: begin
            for (int i = 0; i < list_count && !found; i++) begin
               if (list_tag[i] == tag) begin
                  pos = i;
                  found = 1'b1;
               end
            end
            if (!found) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               res.hit = 1'b1;
               if (cmd == CMD_REMOVE) begin
                  // close up behind the removed entry
                  for (int i = pos; i + 1 < list_count; i++) begin
                     list_rank[i] = list_rank[i+1];
                     list_cost[i] = list_cost[i+1];
                     list_tag[i]  = list_tag[i+1];
                  end
                  list_count--;
                  res.slot = pos[SLOT_W-1:0];
               end
            end
         end
         default: ;
      endcase
      res.count = list_count[COUNT_W-1:0];
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      if (error_count < REPORT_LIMIT)
         $display("%0t mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   // Predict on every accepted command, check every accepted result word.
   always @(posedge clock) begin
      list_result_type want;
      rsp_data_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata[RANK_W-1:0], req_tdata[RANK_W+COST_W-1:RANK_W],
                          req_tdata[REQ_W-1:RANK_W+COST_W], want);
            expected_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result word", 0, 1);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tuser !== want.status) report_mismatch("status", want.status, rsp_tuser);
               if (got.hit !== want.hit) report_mismatch("hit", want.hit, got.hit);
               if (got.slot !== want.slot) report_mismatch("slot", want.slot, got.slot);
               if (got.count !== want.count) report_mismatch("count", want.count, got.count);
               if (got.pad !== '0) report_mismatch("pad", 0, got.pad);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls per word, plus a long hold-off on request.
   initial begin
      int pause_n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_len > 0) begin
            rsp_tready = 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         pause_n = rx_idle ? $urandom_range(0, 17) : 0;
         if (pause_n > 0) begin
            rsp_tready = 1'b0;
            repeat (pause_n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Offer one command word and hold it until accepted. With pick_held the tag is
   // taken from an entry now in the list, so removes and queries mostly hit.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [RANK_W-1:0] rank,
                            input logic [COST_W-1:0] cost, input logic [TAG_W-1:0] tag,
                            input bit pick_held);
      int gap;
      gap = tx_idle ? $urandom_range(0, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (pick_held && list_count > 0) tag = list_tag[$urandom_range(0, list_count - 1)];
      req_tuser = cmd;
      req_tdata = {tag, cost, rank};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int insert_pct);
      logic [CMD_W-1:0]  cmd;
      logic [RANK_W-1:0] rank;
      logic [COST_W-1:0] cost;
      logic [TAG_W-1:0]  tag;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) cmd = CMD_INSERT;
      else begin
         pick = $urandom_range(0, 99);
         cmd = (pick < 65) ? CMD_REMOVE : (pick < 93) ? CMD_QUERY : CMD_UNUSED;
      end
      // narrow ranges make ties and duplicate tags common
      rank = RANK_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
      cost = COST_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 65535));
      tag  = TAG_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 65535));
      send_word(cmd, rank, cost, tag, cmd != CMD_INSERT && $urandom_range(0, 3) != 0);
   endtask

   // Drop valid and wait until every result word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(CMD_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b0);   // empty list
      send_word(CMD_QUERY,  8'hff, 16'hffff, 16'hffff, 1'b0);
      send_word(CMD_UNUSED, 8'hff, 16'hffff, 16'hffff, 1'b0);
      send_word(CMD_INSERT, 8'h00, 16'h0000, 16'h0000, 1'b0);
      send_word(CMD_INSERT, 8'hff, 16'hffff, 16'hffff, 1'b0);
      send_word(CMD_INSERT, 8'hff, 16'hffff, 16'h0001, 1'b0);   // equal key goes ahead
      send_word(CMD_INSERT, 8'hff, 16'h0000, 16'hffff, 1'b0);   // duplicate tag
      send_word(CMD_INSERT, 8'h00, 16'hffff, 16'h0002, 1'b0);   // lands at the end
      send_word(CMD_QUERY,  8'h00, 16'h0000, 16'hffff, 1'b0);
      send_word(CMD_REMOVE, 8'h00, 16'h0000, 16'hffff, 1'b0);   // first match only
      send_word(CMD_QUERY,  8'h00, 16'h0000, 16'h1234, 1'b0);
      send_word(CMD_UNUSED, 8'h5a, 16'ha5a5, 16'h0001, 1'b0);
      for (int k = 0; k < 12; k++)
         send_word(CMD_INSERT, 8'd10 + k[7:0], 16'd100 - k[15:0], 16'h0100 + k[15:0], 1'b0);
      send_word(CMD_INSERT, 8'h80, 16'h0000, 16'h0fff, 1'b0);   // full, dropped
      send_word(CMD_REMOVE, 8'h00, 16'h0000, 16'h0002, 1'b0);   // last slot
   endtask

   task automatic test_full_rate();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      for (int k = 0; k < 100; k++) send_random((k < 50) ? 70 : 30);
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_len = 80;
      tx_idle = 1'b0;
      for (int k = 0; k < 40; k++) send_random(50);
      tx_idle = 1'b1;
   endtask

   task automatic test_drain_pause();
      for (int k = 0; k < 30; k++) send_random(50);
      wait_drained();
      for (int k = 0; k < 20; k++) send_random(50);
   endtask

   // Alternate filling and draining stretches so the list swings between empty and full.
   task automatic test_random_mix();
      int sent;
      int run;
      int pct;
      sent = 0;
      pct = 75;
      while (sent < 930) begin
         run = $urandom_range(20, 60);
         for (int k = 0; k < run; k++) send_random(pct);
         sent += run;
         pct = (pct == 75) ? 25 : 75;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_INSERT;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      hold_len = 0;
      error_count = 0;
      list_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_rate();
      test_backpressure();
      test_drain_pause();
      test_random_mix();

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/spl_pkg.sv
rtl/spl_cell.sv
rtl/sorted_priority_list.sv
rtl/spl_checker.sv
tb/tb.sv
